### design/hbcd_pkg.sv
package hbcd_pkg;

  localparam int unsigned SLOTS_DEF   = 1024;
  localparam int unsigned BUCKETS_DEF = 601;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned FILE_W      = 8;
  localparam int unsigned BLOCK_W     = 23;
  localparam int unsigned SLOT_OUT_W  = 10;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD_RD,
    ST_HEAD_LD,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_MISS,
    ST_SW_CHK,
    ST_SW_V,
    ST_FB_KEY,
    ST_FB_HD,
    ST_FB_CHK,
    ST_LINK_RD,
    ST_LINK_WR
  } state_e;

endpackage

### design/hbcd_ram.sv
module hbcd_ram
  import hbcd_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/hashed_block_cache_directory.sv
// Channel  | Dir | Handshake                  | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser: func; tdata: file_id, block_num
// m_axis   | out | m_axis_tvalid/m_axis_tready | tuser: hit, fill_needed, writeback;
//          |     |                             | tdata: slot, victim_file, victim_block
//
// One item at a time. Each item passes through the bucket hash (reciprocal
// multiply, then multiply back and subtract) and a fetch of the bucket head.
// The walk then reads and compares each chain entry in turn, with a last read
// at the chain end. A hit leaves after its compare. A miss then links the slot
// with a read step and a write step. An eviction adds a check per slot swept
// and a step to unlink the victim. The fallback eviction instead adds a key
// read, a hash of the victim key, and a read of its bucket head that is cleared
// when it points at the victim. After reset a clearing pass writes every bucket
// head empty, with s_axis_tready low. A waiting result holds in the output
// register; the next item is taken in the cycle the result leaves.
module hashed_block_cache_directory
  import hbcd_pkg::*;
#(
  parameter int unsigned SLOTS   = SLOTS_DEF,
  parameter int unsigned BUCKETS = BUCKETS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // file_id[7:0], block_num[30:8], zero
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // slot[9:0], victim_file[17:10], victim_block[40:18]
  output logic [2:0]  m_axis_tuser    // hit[0], fill_needed[1], writeback[2]
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned LW = SW + 1;           // msb set marks an empty link
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [LW-1:0] NIL = {1'b1, {SW{1'b0}}};
  localparam logic [SW:0] SLOTS_C = (SW+1)'(SLOTS);
  // reciprocal of BUCKETS, exact quotient for every KEY_W-bit key
  localparam int unsigned HL  = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
  localparam int unsigned HSH = KEY_W + HL;
  localparam logic [31:0] RECIP =
    32'(((64'd1 << HSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  state_e state_q, state_d;

  // memory ports
  logic            hd_we;
  logic [BW-1:0]   hd_waddr, hd_raddr;
  logic [LW-1:0]   hd_wdata, hd_rdata;
  logic            ln_we;
  logic [SW-1:0]   ln_waddr, ln_raddr;
  logic [LW-1:0]   ln_wdata, ln_rdata;
  logic            ky_we;
  logic [SW-1:0]   ky_waddr, ky_raddr;
  logic [KEY_W-1:0] ky_rdata;

  // request and work registers
  logic [KEY_W-1:0] key_q;
  logic             wr_q;
  logic [BW-1:0]    bkt_q, fbb_q, clr_q;
  logic [KEY_W-1:0] msrc_q;
  logic [63:0]      hprod_q;
  logic             mcnt_q;
  logic             fb_q;
  logic [LW-1:0]    p_q;
  logic [SW:0]      steps_q, sweeps_q, unused_q;
  logic [SW-1:0]    cursor_q, c_q, s_q;
  logic [SW-1:0]    cursor_inc;
  logic [KEY_W-1:0] vkey_q;

  // output register
  logic        ov_q, ohit_q, ofill_q, owb_q;
  logic [SW-1:0] oslot_q;
  logic [KEY_W-1:0] ovkey_q;

  logic accept, out_free;
  logic [KEY_W-1:0] hquo;
  logic [BW-1:0] hrem;

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cursor_inc    = (cursor_q == SW'(SLOTS - 1)) ? '0 : cursor_q + 1'b1;

  // quotient from the top product bits, remainder by multiplying back
  assign hquo = KEY_W'(hprod_q >> HSH);
  assign hrem = BW'(msrc_q - KEY_W'(hquo * KEY_W'(BUCKETS)));

  hbcd_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_waddr), .wdata_i(hd_wdata),
    .raddr_i(hd_raddr), .rdata_o(hd_rdata)
  );
  hbcd_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link (
    .clk_i, .we_i(ln_we), .waddr_i(ln_waddr), .wdata_i(ln_wdata),
    .raddr_i(ln_raddr), .rdata_o(ln_rdata)
  );
  hbcd_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key (
    .clk_i, .we_i(ky_we), .waddr_i(ky_waddr), .wdata_i(key_q),
    .raddr_i(ky_raddr), .rdata_o(ky_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and memory control
  always_comb begin
    state_d  = state_q;
    hd_we    = 1'b0;
    hd_waddr = bkt_q;
    hd_wdata = {1'b0, s_q};
    hd_raddr = bkt_q;
    ln_we    = 1'b0;
    ln_waddr = s_q;
    ln_wdata = hd_rdata;
    ln_raddr = p_q[SW-1:0];
    ky_we    = 1'b0;
    ky_waddr = s_q;
    ky_raddr = p_q[SW-1:0];
    case (state_q)
      ST_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_q;
        hd_wdata = NIL;
        if (clr_q == BW'(BUCKETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_HASH;
      end
      ST_HASH: begin
        if (mcnt_q == '0) state_d = fb_q ? ST_FB_HD : ST_HEAD_RD;
      end
      ST_HEAD_RD: state_d = ST_HEAD_LD;
      ST_HEAD_LD: state_d = ST_WALK_RD;
      ST_WALK_RD: begin
        if (p_q[SW] || steps_q == SLOTS_C) state_d = ST_MISS;
        else state_d = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (ky_rdata == key_q) begin
          if (out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_MISS: begin
        ln_raddr = cursor_q;
        if (unused_q != SLOTS_C) state_d = ST_LINK_RD;
        else state_d = ST_SW_CHK;
      end
      ST_SW_CHK: begin
        ln_raddr = ln_rdata[SW-1:0];
        ky_raddr = ln_rdata[SW-1:0];
        if (!ln_rdata[SW]) begin
          state_d = ST_SW_V;
        end else if (sweeps_q == SLOTS_C) begin
          ky_raddr = cursor_q;
          state_d  = ST_FB_KEY;
        end else begin
          ln_raddr = cursor_q;
          state_d  = ST_SW_CHK;
        end
      end
      ST_SW_V: begin
        // unlink the successor from behind the swept slot
        ln_we    = 1'b1;
        ln_waddr = c_q;
        ln_wdata = ln_rdata;
        state_d  = ST_LINK_RD;
      end
      ST_FB_KEY: state_d = ST_HASH;
      ST_FB_HD: begin
        hd_raddr = fbb_q;
        state_d  = ST_FB_CHK;
      end
      ST_FB_CHK: begin
        hd_waddr = fbb_q;
        hd_wdata = NIL;
        hd_we    = (hd_rdata == {1'b0, s_q});
        state_d  = ST_LINK_RD;
      end
      ST_LINK_RD: state_d = ST_LINK_WR;
      ST_LINK_WR: begin
        if (out_free) begin
          hd_we   = 1'b1;
          ln_we   = 1'b1;
          ky_we   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      unused_q <= '0;
      cursor_q <= '0;
      ov_q     <= 1'b0;
      fb_q     <= 1'b0;
      mcnt_q   <= 1'b0;
      steps_q  <= '0;
      sweeps_q <= '0;
    end else begin
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      if (accept) begin
        fb_q   <= 1'b0;
        mcnt_q <= 1'b1;
      end
      if (state_q == ST_HASH) mcnt_q <= 1'b0;
      if (state_q == ST_HEAD_LD) steps_q <= '0;
      if (state_q == ST_WALK_CHK) begin
        steps_q <= steps_q + 1'b1;
        if (ky_rdata == key_q && out_free) ov_q <= 1'b1;
      end
      if (state_q == ST_MISS) begin
        sweeps_q <= (SW+1)'(1);
        if (unused_q != SLOTS_C) unused_q <= unused_q + 1'b1;
        else cursor_q <= cursor_inc;
      end
      if (state_q == ST_SW_CHK && ln_rdata[SW]) begin
        cursor_q <= cursor_inc;
        if (sweeps_q != SLOTS_C) sweeps_q <= sweeps_q + 1'b1;
      end
      if (state_q == ST_FB_KEY) begin
        fb_q   <= 1'b1;
        mcnt_q <= 1'b1;
      end
      if (state_q == ST_LINK_WR && out_free) ov_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= s_axis_tdata[KEY_W-1:0];
      wr_q   <= s_axis_tuser;
      msrc_q <= s_axis_tdata[KEY_W-1:0];
      owb_q  <= 1'b0;
      vkey_q <= '0;
    end
    if (state_q == ST_HASH) begin
      if (mcnt_q) begin
        hprod_q <= 64'(msrc_q) * 64'(RECIP);
      end else if (fb_q) begin
        fbb_q <= hrem;
      end else begin
        bkt_q <= hrem;
      end
    end
    if (state_q == ST_HEAD_LD) p_q <= hd_rdata;
    if (state_q == ST_WALK_CHK) begin
      if (ky_rdata != key_q) p_q <= ln_rdata;
      if (ky_rdata == key_q && out_free) begin
        ohit_q  <= 1'b1;
        oslot_q <= p_q[SW-1:0];
        ofill_q <= 1'b0;
        owb_q   <= 1'b0;
        ovkey_q <= '0;
      end
    end
    if (state_q == ST_MISS) begin
      s_q <= unused_q[SW-1:0];
      c_q <= cursor_q;
    end
    if (state_q == ST_SW_CHK) begin
      if (!ln_rdata[SW]) s_q <= ln_rdata[SW-1:0];
      else begin
        c_q <= cursor_q;
        if (sweeps_q == SLOTS_C) s_q <= cursor_q;
      end
    end
    if (state_q == ST_SW_V) begin
      vkey_q <= ky_rdata;
      owb_q  <= 1'b1;
    end
    if (state_q == ST_FB_KEY) begin
      vkey_q <= ky_rdata;
      msrc_q <= ky_rdata;
      owb_q  <= 1'b1;
    end
    if (state_q == ST_LINK_WR && out_free) begin
      ohit_q  <= 1'b0;
      oslot_q <= s_q;
      ofill_q <= !wr_q;
      ovkey_q <= vkey_q;
    end
  end

  // the fallback sweep step: the cursor does not advance again in FB_KEY
  // (SW_CHK already advanced it past the victim on the final failed check)

  logic [SLOT_OUT_W-1:0] slot_out;
  if (SW >= SLOT_OUT_W) begin : g_slot_trunc
    assign slot_out = oslot_q[SLOT_OUT_W-1:0];
  end else begin : g_slot_ext
    assign slot_out = SLOT_OUT_W'(oslot_q);
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = {ov_q & owb_q, ov_q & ofill_q, ov_q & ohit_q};
  assign m_axis_tdata  = {7'b0, ovkey_q[KEY_W-1:FILE_W], ovkey_q[FILE_W-1:0], slot_out};

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("item taken during bucket clear");

  a_unused_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unused_q <= SLOTS_C)
    else $error("slot allocation count past SLOTS");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> ($past(state_q) == ST_WALK_CHK || $past(state_q) == ST_LINK_WR))
    else $error("result appeared outside hit or link step");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ohit_q) |-> (!owb_q && !ofill_q))
    else $error("hit result carries miss flags");

endmodule

### sim/hbcd_directory_checker.sv
`timescale 1ns / 1ps
// Watches both streams, keeps a shadow copy of the directory and checks every
// result item against the lookup result that the shadow directory predicts.
module hbcd_directory_checker
  import hbcd_pkg::*;
#(
  parameter int unsigned SLOTS   = SLOTS_DEF,
  parameter int unsigned BUCKETS = BUCKETS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NONE = -1;

  typedef struct packed {
    logic               hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic               fill;
    logic               wb;
    logic [FILE_W-1:0]  vfile;
    logic [BLOCK_W-1:0] vblock;
  } lookup_t;

  int             head_q [BUCKETS];
  int             link_q [SLOTS];
  logic [KEY_W-1:0] key_q [SLOTS];
  int             taken_q;
  int             cursor_q;
  lookup_t        lookups_due[$];

  assign pending_o = lookups_due.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Free one slot; return it and the key it held.
  function automatic int evict_slot(output logic [KEY_W-1:0] vkey);
    int c, v, b;
    for (int n = 0; n < SLOTS; n++) begin
      c = cursor_q;
      cursor_q = (c + 1) % SLOTS;
      if (link_q[c] != NONE) begin
        v = link_q[c];
        link_q[c] = link_q[v];
        link_q[v] = NONE;
        vkey = key_q[v];
        return v;
      end
    end
    // every slot alone in its bucket: drop the one under the cursor
    c = cursor_q;
    cursor_q = (c + 1) % SLOTS;
    b = key_q[c] % BUCKETS;
    if (head_q[b] == c) head_q[b] = NONE;
    link_q[c] = NONE;
    vkey = key_q[c];
    return c;
  endfunction

  function automatic lookup_t lookup_block(input logic is_write, input logic [KEY_W-1:0] k);
    lookup_t r;
    int b, p, s;
    logic [KEY_W-1:0] vkey;
    r = '0;
    b = k % BUCKETS;
    p = head_q[b];
    for (int steps = 0; p != NONE && steps < SLOTS; steps++) begin
      if (key_q[p] == k) begin
        r.hit = 1'b1;
        r.slot = p[SLOT_OUT_W-1:0];
        return r;
      end
      p = link_q[p];
    end
    if (taken_q < SLOTS) begin
      s = taken_q;
      taken_q++;
    end else begin
      s = evict_slot(vkey);
      r.wb = 1'b1;
      r.vfile = vkey[FILE_W-1:0];
      r.vblock = vkey[KEY_W-1:FILE_W];
    end
    link_q[s] = head_q[b];
    head_q[b] = s;
    key_q[s] = k;
    r.slot = s[SLOT_OUT_W-1:0];
    r.fill = !is_write;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      foreach (head_q[i]) head_q[i] = NONE;
      foreach (link_q[i]) begin
        link_q[i] = NONE;
        key_q[i] = '0;
      end
      taken_q = 0;
      cursor_q = 0;
      fail_count_o = 0;
      lookups_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lookups_due.size() == 0) begin
          report("unexpected item", m_axis_tdata, 0);
        end else begin
          want = lookups_due.pop_front();
          if (m_axis_tuser[0] !== want.hit) report("hit", m_axis_tuser[0], want.hit);
          if (m_axis_tdata[9:0] !== want.slot) report("slot", m_axis_tdata[9:0], want.slot);
          if (m_axis_tuser[1] !== want.fill) report("fill", m_axis_tuser[1], want.fill);
          if (m_axis_tuser[2] !== want.wb) report("writeback", m_axis_tuser[2], want.wb);
          if (m_axis_tdata[17:10] !== want.vfile)
            report("victim_file", m_axis_tdata[17:10], want.vfile);
          if (m_axis_tdata[40:18] !== want.vblock)
            report("victim_block", m_axis_tdata[40:18], want.vblock);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        lookups_due.push_back(lookup_block(s_axis_tuser, s_axis_tdata[30:0]));
    end
  end

endmodule

### sim/hashed_block_cache_directory_tb.sv
`timescale 1ns / 1ps
module hashed_block_cache_directory_tb;
  import hbcd_pkg::*;

  localparam int RANDOM_ITEMS = 1840;
  localparam int QUIET_TAIL   = 200;
  localparam int STALL_LIMIT  = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  bit          quiet = 1'b0;
  int          idle_cycles = 0;
  logic [30:0] seen_keys[$];

  always #4 clk_i = ~clk_i;

  hashed_block_cache_directory dut (.*);

  hbcd_directory_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  // Receiver: stall in random bursts, hold ready high in the quiet tail.
  always @(posedge clk_i) begin
    int run;
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (run > 0) begin
      run--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0) ? 1'b1 : 1'b0;
      run = $urandom_range(0, 16);
    end
  end

  // Watchdog: abort when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one item and hold it until it is accepted.
  task automatic send_item(input logic is_write, input logic [30:0] k);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= is_write;
    s_axis_tdata <= {1'b0, k};
    do @(posedge clk_i); while (!s_axis_tready);
    seen_keys.push_back(k);
  endtask

  task automatic pause_sender(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [30:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25 && seen_keys.size() > 0)
      return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    // crowd a few buckets to build long chains
    if (r < 70)
      return 31'($urandom_range(0, 7) + BUCKETS_DEF * $urandom_range(0, 3500000));
    return 31'($urandom);
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, hits of both kinds, same-bucket chains.
    send_item(1'b0, 31'h0);
    send_item(1'b1, 31'h0);
    send_item(1'b1, 31'h7FFF_FFFF);
    send_item(1'b0, 31'h7FFF_FFFF);
    send_item(1'b0, 31'(BUCKETS_DEF));
    send_item(1'b1, 31'(2 * BUCKETS_DEF));
    send_item(1'b0, 31'(3 * BUCKETS_DEF));
    send_item(1'b0, 31'h0);
    send_item(1'b1, 31'(BUCKETS_DEF));
    send_item(1'b0, {23'h7F_FFFF, 8'h00});
    send_item(1'b1, {23'h00_0000, 8'hFF});
    send_item(1'b0, {23'h55_5555, 8'hAA});
    send_item(1'b1, {23'h2A_AAAA, 8'h55});

    // Drain the directory before the random part.
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);

    // Random: fills every slot, then forces evictions.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 17));
      send_item(1'($urandom_range(0, 1)), pick_key());
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### hashed_block_cache_directory.f
design/hbcd_pkg.sv
design/hbcd_ram.sv
design/hashed_block_cache_directory.sv
sim/hbcd_directory_checker.sv
sim/hashed_block_cache_directory_tb.sv
